// File: design/tlpm_pkg.sv
`timescale 1ns / 1ps

package tlpm_pkg;

    localparam int unsigned TABLE_ENTRIES = 1024;
    localparam int unsigned IDX_W         = 10;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 20;

    localparam logic [IDX_W-1:0] IDX_LAST   = 10'h3ff;
    localparam logic [31:0]      SUPER_MARK = 32'h0000_0081;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_SPLIT = 3'd0,
        CFG_SUPERPAGES   = 3'd1,
        CFG_KERNEL_PERMS = 3'd2,
        CFG_USER_PERMS   = 3'd3,
        CFG_POOL_BASE    = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_KERNEL      = 3'd1,
        ST_SUPERPAGE   = 3'd2,
        ST_MAPPED      = 3'd3,
        ST_POOL_EMPTY  = 3'd4
    } status_t;

    typedef struct packed {
        logic [10:0] split;
        logic [10:0] superpages;
        logic [11:0] kperms;
        logic [11:0] uperms;
        logic [19:0] base;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] dir_entry;
        logic [31:0] table_entry;
    } res_t;

endpackage

// File: design/tlpm_ram.sv
`timescale 1ns / 1ps

module tlpm_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/tlpm_ctrl.sv
`timescale 1ns / 1ps

module tlpm_ctrl #(
    parameter int unsigned POOL_TABLES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                op,
    input  logic [31:0]         virt_address,
    input  logic [31:0]         phys_address,
    output logic                in_stall,
    input  tlpm_pkg::cfg_t      cfg,
    input  logic                out_free,
    output logic                res_load,
    output tlpm_pkg::res_t      res
);

    localparam int unsigned KW  = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int unsigned UW  = $clog2(POOL_TABLES + 1);
    localparam int unsigned PAW = $clog2(POOL_TABLES * tlpm_pkg::TABLE_ENTRIES);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIR   = 7'b0000100,
        S_ALLOC = 7'b0001000,
        S_TAB   = 7'b0010000,
        S_INIT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [tlpm_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [tlpm_pkg::IDX_W-1:0]   didx_reg, didx_next;
    logic [tlpm_pkg::IDX_W-1:0]   tidx_reg, tidx_next;
    logic [19:0]                  phys_reg, phys_next;
    logic [KW-1:0]                k_reg, k_next;
    logic [31:0]                  pde_reg, pde_next;
    logic [UW-1:0]                used_reg, used_next;
    tlpm_pkg::res_t               res_reg, res_next;

    logic                         dir_we;
    logic [tlpm_pkg::IDX_W-1:0]   dir_addr;
    logic [31:0]                  dir_wdata;
    logic [31:0]                  dir_rdata;
    logic                         pool_we;
    logic [PAW-1:0]               pool_addr;
    logic [31:0]                  pool_wdata;
    logic [31:0]                  pool_rdata;

    logic [19:0]                  kfull;
    logic [19:0]                  used_ext;
    logic [31:0]                  new_pte;
    logic [31:0]                  new_pde;

    // entry that init leaves at directory index d
    function automatic logic [31:0] super_entry(
        input logic [tlpm_pkg::IDX_W-1:0] d,
        input tlpm_pkg::cfg_t             c
    );
        logic [10:0] i;
        logic [31:0] e;
        i = {1'b0, d} - c.split;
        e = '0;
        if (({1'b0, d} >= c.split) && (i < c.superpages))
        begin
            e = {i[9:0], 22'd0} | {20'd0, c.kperms};
        end
        return e;
    endfunction

    tlpm_ram #(
        .DEPTH (tlpm_pkg::TABLE_ENTRIES),
        .AW    (tlpm_pkg::IDX_W)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .addr  (dir_addr),
        .wdata (dir_wdata),
        .rdata (dir_rdata)
    );

    tlpm_ram #(
        .DEPTH (POOL_TABLES * tlpm_pkg::TABLE_ENTRIES),
        .AW    (PAW)
    ) u_pool_ram (
        .clk   (clk),
        .we    (pool_we),
        .addr  (pool_addr),
        .wdata (pool_wdata),
        .rdata (pool_rdata)
    );

    assign used_ext = {{(20 - UW){1'b0}}, used_reg};
    assign kfull    = dir_rdata[31:12] - cfg.base;
    assign new_pte  = {phys_reg, 12'd0} | {20'd0, cfg.uperms};
    assign new_pde  = {cfg.base + used_ext, 12'd0} | {20'd0, cfg.uperms};

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        didx_next  = didx_reg;
        tidx_next  = tidx_reg;
        phys_next  = phys_reg;
        k_next     = k_reg;
        pde_next   = pde_reg;
        used_next  = used_reg;
        res_next   = res_reg;
        dir_we     = 1'b0;
        dir_addr   = idx_reg;
        dir_wdata  = '0;
        pool_we    = 1'b0;
        pool_addr  = PAW'({k_reg, tidx_reg});
        pool_wdata = new_pte;
        res_load   = 1'b0;
        in_stall   = 1'b1;

        case (state_reg)
            S_CLEAR:
            begin
                dir_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == tlpm_pkg::IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_stall = 1'b0;
                dir_addr = virt_address[31:22];
                if (in_valid)
                begin
                    didx_next = virt_address[31:22];
                    tidx_next = virt_address[21:12];
                    phys_next = phys_address[31:12];
                    idx_next  = '0;
                    if (op)
                    begin
                        state_next = S_DIR;
                    end
                    else
                    begin
                        used_next             = '0;
                        res_next.status       = tlpm_pkg::ST_OK;
                        res_next.dir_entry    = super_entry(virt_address[31:22], cfg);
                        res_next.table_entry  = '0;
                        state_next            = S_INIT;
                    end
                end
            end

            S_DIR:
            begin
                dir_addr             = didx_reg;
                pool_addr            = PAW'({kfull[KW-1:0], tidx_reg});
                res_next.dir_entry   = dir_rdata;
                res_next.table_entry = '0;
                pde_next             = dir_rdata;
                state_next           = S_DONE;
                if ({1'b0, didx_reg} >= cfg.split)
                begin
                    res_next.status = tlpm_pkg::ST_KERNEL;
                end
                else if ((dir_rdata & tlpm_pkg::SUPER_MARK) == tlpm_pkg::SUPER_MARK)
                begin
                    res_next.status = tlpm_pkg::ST_SUPERPAGE;
                end
                else if (dir_rdata[0])
                begin
                    // table must be one already handed out
                    if (kfull >= used_ext)
                    begin
                        res_next.status = tlpm_pkg::ST_POOL_EMPTY;
                    end
                    else
                    begin
                        k_next     = kfull[KW-1:0];
                        state_next = S_TAB;
                    end
                end
                else if (used_reg >= UW'(POOL_TABLES))
                begin
                    res_next.status = tlpm_pkg::ST_POOL_EMPTY;
                end
                else
                begin
                    dir_we     = 1'b1;
                    dir_wdata  = new_pde;
                    pde_next   = new_pde;
                    k_next     = used_reg[KW-1:0];
                    used_next  = used_reg + UW'(1);
                    idx_next   = '0;
                    state_next = S_ALLOC;
                end
            end

            S_ALLOC:
            begin
                // clear the fresh table, dropping the new entry in on the way
                pool_we    = 1'b1;
                pool_addr  = PAW'({k_reg, idx_reg});
                pool_wdata = (idx_reg == tidx_reg) ? new_pte : 32'd0;
                idx_next   = idx_reg + 1'b1;
                if (idx_reg == tlpm_pkg::IDX_LAST)
                begin
                    res_next.status      = tlpm_pkg::ST_OK;
                    res_next.dir_entry   = pde_reg;
                    res_next.table_entry = new_pte;
                    state_next           = S_DONE;
                end
            end

            S_TAB:
            begin
                res_next.dir_entry = pde_reg;
                state_next         = S_DONE;
                if (pool_rdata[0])
                begin
                    res_next.status      = tlpm_pkg::ST_MAPPED;
                    res_next.table_entry = pool_rdata;
                end
                else
                begin
                    pool_we              = 1'b1;
                    res_next.status      = tlpm_pkg::ST_OK;
                    res_next.table_entry = new_pte;
                end
            end

            S_INIT:
            begin
                dir_we    = 1'b1;
                dir_wdata = super_entry(idx_reg, cfg);
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == tlpm_pkg::IDX_LAST)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg <= didx_next;
        tidx_reg <= tidx_next;
        phys_reg <= phys_next;
        k_reg    <= k_next;
        pde_reg  <= pde_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(POOL_TABLES))
        else $error("pool use count past pool size");

    a_pool_write_owned: assert property (@(posedge clk) disable iff (!rst_n)
        pool_we |-> (UW'(k_reg) < used_reg))
        else $error("write to a pool table not handed out");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while busy");

    a_result_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (state_reg == S_IDLE) && (used_reg == $past(used_reg)))
        else $error("result hand-off disturbed state");
`endif

endmodule

// File: design/two_level_page_table_mapper_unit.sv
`timescale 1ns / 1ps

// Two-level page mapper with a 1024-entry page directory and a pool of
// POOL_TABLES page tables, both held in single-port synchronous RAMs. Each
// request is worked on alone. A map request to a directory entry that is
// already present goes from acceptance to result through directory read,
// table read, check/write and hand-off; rejected maps go from directory
// read to hand-off. A map that needs a new table and an init are both
// held up by a sweep that clears the 1024 table entries or rewrites the
// 1024 directory entries one per cycle through the single RAM port. After
// reset the directory is cleared in a pass during which no request is taken;
// configuration writes are taken at any time and must only come while idle.
// A result waits in an output register, so the next request can start
// while the previous result is still stalled.
module two_level_page_table_mapper_unit #(
    parameter int unsigned POOL_TABLES = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] virt_address,
    input  logic [31:0] phys_address,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] dir_entry,
    output logic [31:0] table_entry
);

    tlpm_pkg::cfg_t cfg_reg, cfg_next;
    tlpm_pkg::res_t res;
    tlpm_pkg::res_t out_reg;
    logic           out_valid_reg;
    logic           out_free;
    logic           res_load;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                tlpm_pkg::CFG_KERNEL_SPLIT: cfg_next.split      = cfg_data[10:0];
                tlpm_pkg::CFG_SUPERPAGES:   cfg_next.superpages = cfg_data[10:0];
                tlpm_pkg::CFG_KERNEL_PERMS: cfg_next.kperms     = cfg_data[11:0];
                tlpm_pkg::CFG_USER_PERMS:   cfg_next.uperms     = cfg_data[11:0];
                tlpm_pkg::CFG_POOL_BASE:    cfg_next.base       = cfg_data;
                default:                    cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.split      <= 11'd768;
            cfg_reg.superpages <= 11'd64;
            cfg_reg.kperms     <= 12'd131;
            cfg_reg.uperms     <= 12'd7;
            cfg_reg.base       <= 20'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tlpm_ctrl #(
        .POOL_TABLES (POOL_TABLES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .op           (op),
        .virt_address (virt_address),
        .phys_address (phys_address),
        .in_stall     (in_stall),
        .cfg          (cfg_reg),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res)
    );

    // output slot frees up in the same cycle its request is taken
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign dir_entry   = out_reg.dir_entry;
    assign table_entry = out_reg.table_entry;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned POOL         = 16;
    localparam int          ITEM_TARGET  = 580;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          SETTLE       = 100;
    localparam int          CYCLE_LIMIT  = 3_000_000;

    localparam logic        OP_INIT   = 1'b0;
    localparam logic        OP_MAP    = 1'b1;
    localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

    class mapper_scoreboard;
        logic [10:0] split;
        logic [10:0] superpages;
        logic [11:0] kperms;
        logic [11:0] uperms;
        logic [19:0] base;
        logic [31:0] directory_image [0:1023];
        logic [31:0] pool_image [0:POOL*tlpm_pkg::TABLE_ENTRIES-1];
        int unsigned tables_taken;
        tlpm_pkg::res_t outcomes_due [$];
        int          errors;
        int          status_seen [0:4];

        function new();
            errors = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (directory_image[i])
                directory_image[i] = 32'd0;
            foreach (pool_image[i])
                pool_image[i] = 32'd0;
            tables_taken = 0;
        endfunction

        function void set_config(tlpm_pkg::cfg_t c);
            split      = c.split;
            superpages = c.superpages;
            kperms     = c.kperms;
            uperms     = c.uperms;
            base       = c.base;
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        // works out the result of one accepted request and updates the tables
        function void note_request(logic op_i, logic [31:0] va, logic [31:0] pa);
            logic [9:0]  didx;
            logic [9:0]  tidx;
            logic [31:0] phys;
            logic [31:0] pde;
            logic [31:0] pte;
            logic [19:0] k;
            logic [19:0] tpage;
            int unsigned slot;
            int unsigned d;
            tlpm_pkg::res_t r;
            didx = va[31:22];
            tidx = va[21:12];
            phys = pa & PAGE_MASK;
            if (op_i == OP_INIT)
            begin
                wipe();
                for (int unsigned i = 0; i < superpages; i++)
                begin
                    d = split + i;
                    if (d >= 1024)
                        break;
                    directory_image[d] = (i << 22) | {20'd0, kperms};
                end
                r = '{tlpm_pkg::ST_OK, directory_image[didx], 32'd0};
            end
            else
            begin
                pde = directory_image[didx];
                if ({1'b0, didx} >= split)
                    r = '{tlpm_pkg::ST_KERNEL, pde, 32'd0};
                else if ((pde & tlpm_pkg::SUPER_MARK) == tlpm_pkg::SUPER_MARK)
                    r = '{tlpm_pkg::ST_SUPERPAGE, pde, 32'd0};
                else if (pde[0])
                begin
                    // table must be one already handed out from the pool
                    k = pde[31:12] - base;
                    if (k >= tables_taken || k >= POOL)
                        r = '{tlpm_pkg::ST_POOL_EMPTY, pde, 32'd0};
                    else
                    begin
                        slot = k * tlpm_pkg::TABLE_ENTRIES + tidx;
                        pte  = pool_image[slot];
                        if (pte[0])
                            r = '{tlpm_pkg::ST_MAPPED, pde, pte};
                        else
                        begin
                            pte = phys | {20'd0, uperms};
                            pool_image[slot] = pte;
                            r = '{tlpm_pkg::ST_OK, pde, pte};
                        end
                    end
                end
                else if (tables_taken >= POOL)
                    r = '{tlpm_pkg::ST_POOL_EMPTY, pde, 32'd0};
                else
                begin
                    k = tables_taken[19:0];
                    tables_taken++;
                    for (int unsigned e = 0; e < tlpm_pkg::TABLE_ENTRIES; e++)
                        pool_image[k * tlpm_pkg::TABLE_ENTRIES + e] = 32'd0;
                    tpage = base + k;
                    pde = {tpage, 12'h000} | {20'd0, uperms};
                    directory_image[didx] = pde;
                    pte = phys | {20'd0, uperms};
                    pool_image[k * tlpm_pkg::TABLE_ENTRIES + tidx] = pte;
                    r = '{tlpm_pkg::ST_OK, pde, pte};
                end
            end
            outcomes_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_outcome(logic [2:0] st, logic [31:0] de, logic [31:0] te);
            tlpm_pkg::res_t r;
            if (outcomes_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, actual %0d %h %h",
                         $time, st, de, te);
            end
            else
            begin
                r = outcomes_due.pop_front();
                status_seen[r.status]++;
                compare_field("status", {29'd0, r.status}, {29'd0, st});
                compare_field("dir_entry", r.dir_entry, de);
                compare_field("table_entry", r.table_entry, te);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [19:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [31:0] virt_address;
    logic [31:0] phys_address;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [31:0] dir_entry;
    logic [31:0] table_entry;

    mapper_scoreboard sb;
    logic        calm;
    int          hold_asks;
    int          hold_served;
    int          hold_left;
    int          cycles;
    int          requests_sent;
    int          configs_applied;
    logic [9:0]  region_pick [0:2];
    logic [9:0]  slot_pick [0:3];

    two_level_page_table_mapper_unit #(
        .POOL_TABLES (POOL)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .virt_address (virt_address),
        .phys_address (phys_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .dir_entry    (dir_entry),
        .table_entry  (table_entry)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("two_level_page_table_mapper_unit: mismatch");
            $finish;
        end
    end

    // result side: check, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_outcome(status, dir_entry, table_entry);
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_served != hold_asks)
        begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES - 1;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 12);
    end

    task automatic send_request(input logic op_i, input logic [31:0] va,
                                input logic [31:0] pa);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 12)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= op_i;
        virt_address <= va;
        phys_address <= pa;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(op_i, va, pa);
        requests_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // registers only change while nothing is in flight
    task automatic apply_config(input tlpm_pkg::cfg_t c);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= tlpm_pkg::CFG_KERNEL_SPLIT;
        cfg_data  <= {9'd0, c.split};
        @(posedge clk);
        cfg_index <= tlpm_pkg::CFG_SUPERPAGES;
        cfg_data  <= {9'd0, c.superpages};
        @(posedge clk);
        cfg_index <= tlpm_pkg::CFG_KERNEL_PERMS;
        cfg_data  <= {8'd0, c.kperms};
        @(posedge clk);
        cfg_index <= tlpm_pkg::CFG_USER_PERMS;
        cfg_data  <= {8'd0, c.uperms};
        @(posedge clk);
        cfg_index <= tlpm_pkg::CFG_POOL_BASE;
        cfg_data  <= c.base;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_config(c);
        configs_applied++;
    endtask

    function automatic tlpm_pkg::cfg_t random_config();
        tlpm_pkg::cfg_t c;
        int   r;
        case ($urandom_range(9))
            0: c.split = 11'd0;
            1: c.split = 11'd1024;
            2: c.split = 11'd1023;
            3: c.split = 11'd768;
            default: c.split = 11'($urandom_range(1, 1024));
        endcase
        case ($urandom_range(7))
            0: c.superpages = 11'd0;
            1: c.superpages = 11'd1024;
            default: c.superpages = 11'($urandom_range(0, 1024));
        endcase
        c.kperms = 12'($urandom_range(4095));
        r = $urandom_range(99);
        if (r < 70)
            c.uperms = (12'($urandom_range(4095)) | 12'h001) & ~12'h080;
        else if (r < 85)
            c.uperms = 12'($urandom_range(4095)) & ~12'h001;
        else
            c.uperms = 12'($urandom_range(4095));
        case ($urandom_range(7))
            0: c.base = 20'h00000;
            1: c.base = 20'hfffff;
            2: c.base = 20'hffff8;
            default: c.base = 20'($urandom_range(20'hfffff));
        endcase
        return c;
    endfunction

    // mostly a few regions and slots per phase so that tables get reused
    function automatic logic [31:0] pick_address();
        logic [9:0] didx;
        logic [9:0] tidx;
        int         r;
        r = $urandom_range(99);
        if (r >= 85)
            return $urandom();
        if (r < 70)
            didx = region_pick[$urandom_range(2)];
        else
            didx = 10'($urandom_range(1023));
        if ($urandom_range(99) < 60)
            tidx = slot_pick[$urandom_range(3)];
        else
            tidx = 10'($urandom_range(1023));
        return {didx, tidx, 12'($urandom_range(4095))};
    endfunction

    task automatic run_directed();
        apply_config('{11'd768, 11'd64, 12'h083, 12'h007, 20'h00000});
        send_request(OP_INIT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_INIT, 32'hc040_0000, 32'hffff_ffff);
        send_request(OP_MAP, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_MAP, 32'h0000_0fff, 32'hffff_ffff);
        send_request(OP_MAP, 32'h003f_f000, 32'hffff_f000);
        send_request(OP_MAP, 32'hbfff_ffff, 32'h1234_5678);
        send_request(OP_MAP, 32'hc000_0000, 32'h0000_1000);
        send_request(OP_MAP, 32'hffff_ffff, 32'hffff_ffff);
        // long hold-off on the result side while fast maps keep coming
        hold_asks <= hold_asks + 1;
        for (int n = 1; n <= 6; n++)
            send_request(OP_MAP, 32'(n) << 12, $urandom());
        // split at zero: every address is kernel space
        apply_config('{11'd0, 11'd1024, 12'hfff, 12'hfff, 20'hfffff});
        send_request(OP_INIT, 32'hffff_ffff, 32'h0000_0000);
        send_request(OP_MAP, 32'h0000_0000, 32'hffff_ffff);
        // split moved past the end without init: superpages now in user space
        apply_config('{11'd1024, 11'd1024, 12'hfff, 12'hfff, 20'hfffff});
        send_request(OP_MAP, 32'hffff_f000, 32'h0000_0000);
        // user perms carrying the superpage mark, pool base wrapping
        apply_config('{11'd1024, 11'd0, 12'h000, 12'hfff, 20'hfffff});
        send_request(OP_INIT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_MAP, 32'hffc0_0000, 32'haaaa_a000);
        send_request(OP_MAP, 32'hffc0_1000, 32'h5555_5000);
        // user perms without present bit: same region takes a second table
        apply_config('{11'd1024, 11'd1, 12'h080, 12'h006, 20'h00002});
        send_request(OP_INIT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_MAP, 32'h0040_0000, 32'h0000_1000);
        send_request(OP_MAP, 32'h0040_1000, 32'h0000_2000);
        // base moved after mapping: entry points outside the pool
        apply_config('{11'd768, 11'd64, 12'h083, 12'h007, 20'h00000});
        send_request(OP_INIT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_MAP, 32'h0000_0000, 32'h0000_3000);
        apply_config('{11'd768, 11'd64, 12'h083, 12'h007, 20'h00003});
        send_request(OP_MAP, 32'h0000_1000, 32'h0000_4000);
    endtask

    task automatic run_phase(input int phase_no);
        tlpm_pkg::cfg_t c;
        int   maps;
        c = random_config();
        apply_config(c);
        for (int j = 0; j < 3; j++)
            region_pick[j] = (c.split == 0) ? 10'($urandom_range(1023))
                                            : 10'($urandom_range(0, c.split - 1));
        for (int j = 0; j < 4; j++)
            slot_pick[j] = 10'($urandom_range(1023));
        calm <= (phase_no == 6 || phase_no == 7);
        if (phase_no == 4)
            hold_asks <= hold_asks + 1;
        if ($urandom_range(99) < 85)
            send_request(OP_INIT, $urandom(), $urandom());
        maps = $urandom_range(10, 35);
        repeat (maps)
            send_request(OP_MAP, pick_address(), $urandom());
    endtask

    initial
    begin
        int target;
        int phase_no;
        sb           = new();
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = tlpm_pkg::CFG_KERNEL_SPLIT;
        cfg_data     = 20'd0;
        in_valid     = 1'b0;
        op           = OP_INIT;
        virt_address = 32'd0;
        phys_address = 32'd0;
        out_stall    = 1'b0;
        calm         = 1'b0;
        hold_asks    = 0;
        hold_served  = 0;
        hold_left    = 0;
        cycles       = 0;
        requests_sent   = 0;
        configs_applied = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        target   = ITEM_TARGET;
        phase_no = 0;
        while (requests_sent < target)
        begin
            run_phase(phase_no);
            phase_no++;
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d requests under %0d register settings",
                 requests_sent, configs_applied);
        $display("results: %0d ok, %0d kernel, %0d superpage, %0d mapped, %0d pool empty",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("two_level_page_table_mapper_unit: match");
        else
            $display("two_level_page_table_mapper_unit: mismatch");
        $finish;
    end

endmodule

// File: two_level_page_table_mapper_unit.f
design/tlpm_pkg.sv
design/tlpm_ram.sv
design/tlpm_ctrl.sv
design/two_level_page_table_mapper_unit.sv
sim/tb.sv
